// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file of the distance block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define HVD_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HVD_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/hvd_pkg.sv -----
// ----------------------------------------------------------------------------
// hvd_pkg
// Widths, fixed-point constants, CORDIC arctangent table and the records that
// travel along the cell chains of the great-circle distance pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvd_pkg;

  localparam int XW         = 32;  // CORDIC rotation x/y, Q30
  localparam int ZW         = 36;  // rotation angle, Q30
  localparam int TW         = 29;  // angle in ten-thousandths of a minute
  localparam int PW         = 62;  // angle times radian scale
  localparam int QW         = 34;  // squared / scaled products, Q30
  localparam int CW         = 33;  // signed cosine, Q30
  localparam int AW         = 31;  // clamped a, Q30 in [0, 1]
  localparam int RW         = 62;  // square root remainder and root
  localparam int VW         = 33;  // vectoring x/y/z, Q30
  localparam int SQRT_STEPS = 31;

  localparam logic [63:0] PI_Q61      = 64'h6487ED5110B4611A;
  localparam logic [63:0] DEG_DIV     = 64'd600000 * 64'd180 * 64'd32;
  localparam logic [63:0] RAD_K       = (PI_Q61 + DEG_DIV / 2) / DEG_DIV;
  localparam logic [63:0] PI_Q30      = (PI_Q61 + (64'd1 << 30)) >> 31;
  localparam logic [63:0] HALF_PI_Q30 = (PI_Q61 + (64'd1 << 31)) >> 32;
  localparam logic [XW-1:0] GAIN_INV  = 32'h26DD3B6A;
  localparam logic [AW-1:0] ONE_Q30   = 31'h40000000;

  localparam logic [15:0] RADIUS_RESET     = 16'd3440;
  localparam logic [0:0]  REG_EARTH_RADIUS = 1'b0;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
    32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
    32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 flip;
  } rot_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [RW-1:0] root;
  } sqrt_t;

  typedef struct packed {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
  } vec_t;

endpackage

// ----- hdl/hvd_rot_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_rot_cell
// One rotation-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvd_rot_cell import hvd_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic adv,
  input  rot_t d,
  output rot_t q
);

  localparam logic signed [ZW-1:0] ANG = $signed(ZW'(ATAN_Q30[IDX]));

  logic signed [XW-1:0] xs, ys, dx, dy;
  rot_t q_next;

  always_comb begin
    xs = d.x;
    ys = d.y;
    dx = ys >>> IDX;
    dy = xs >>> IDX;
    q_next.flip = d.flip;
    if (!d.z[ZW-1]) begin
      q_next.x = xs - dx;
      q_next.y = ys + dy;
      q_next.z = d.z - ANG;
    end else begin
      q_next.x = xs + dx;
      q_next.y = ys - dy;
      q_next.z = d.z + ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= q_next;
    end
  end

endmodule

// ----- hdl/hvd_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_sqrt_cell
// One digit step of the restoring integer square root, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvd_sqrt_cell import hvd_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  adv,
  input  sqrt_t d,
  output sqrt_t q
);

  localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - STEP));

  logic [RW-1:0] trial;
  sqrt_t q_next;

  always_comb begin
    trial = d.root + BIT;
    if (d.rem >= trial) begin
      q_next.rem  = d.rem - trial;
      q_next.root = (d.root >> 1) + BIT;
    end else begin
      q_next.rem  = d.rem;
      q_next.root = d.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= q_next;
    end
  end

endmodule

// ----- hdl/hvd_vec_cell.sv -----
// ----------------------------------------------------------------------------
// hvd_vec_cell
// One vectoring-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvd_vec_cell import hvd_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic adv,
  input  vec_t d,
  output vec_t q
);

  localparam logic signed [VW-1:0] ANG = $signed(VW'(ATAN_Q30[IDX]));

  logic signed [VW-1:0] xs, ys, dx, dy;
  vec_t q_next;

  always_comb begin
    xs = d.x;
    ys = d.y;
    dx = ys >>> IDX;
    dy = xs >>> IDX;
    if (!ys[VW-1] && (ys != '0)) begin
      q_next.x = xs + dx;
      q_next.y = ys - dy;
      q_next.z = d.z + ANG;
    end else begin
      q_next.x = xs - dx;
      q_next.y = ys + dy;
      q_next.z = d.z - ANG;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q <= q_next;
    end
  end

endmodule

// ----- hdl/haversine_distance.sv -----
// ----------------------------------------------------------------------------
// haversine_distance
// Great-circle distance between two positions given in signed ten-thousandths
// of a minute. The block takes one position pair per cycle while the output
// is not blocked, and returns the distance in nautical miles with 8 fraction
// bits, saturating at 0xFFFFFF. The pipeline holds four front stages
// (difference, radian scaling, rounding, quadrant fold), CORDIC_STAGES
// rotation cells for the four sines/cosines, four product stages, 31 square
// root cells, CORDIC_STAGES vectoring cells for atan2, and two output stages.
// The whole pipeline advances together and stalls only while a finished
// distance waits at the output. The user must see that the radius register
// (address 0, reset 3440) is written through the APB port while no item is in
// flight; the block itself does not enforce this. No inputs are range checked.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_distance import hvd_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  // position pair
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [27:0] first_longitude,
  input  logic signed [26:0] first_latitude,
  input  logic signed [27:0] second_longitude,
  input  logic signed [26:0] second_latitude,
  // distance
  output logic               out_valid,
  input  logic               out_ready,
  output logic        [23:0] distance_q8,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic         [2:0] paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  localparam int N   = CORDIC_STAGES;
  localparam int LAT = 2 * N + 41;

  localparam logic signed [2*XW-1:0]    RND1 = (2*XW)'(1) << 29;
  localparam logic signed [QW+CW-1:0]   RND2 = (QW+CW)'(1) << 29;
  localparam logic signed [ZW-1:0]      HP   = $signed(ZW'(HALF_PI_Q30));
  localparam logic signed [ZW-1:0]      PI   = $signed(ZW'(PI_Q30));

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [15:0] radius;
  logic        reg_sel;

  assign reg_sel = (paddr[2:2] == REG_EARTH_RADIUS);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {16'b0, radius} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      radius <= pwdata[15:0];
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: every stage moves on together unless the output is blocked
  // --------------------------------------------------------------------------
  logic           adv;
  logic [LAT-1:0] vld;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // --------------------------------------------------------------------------
  // Front end. Lanes: 0 latitude difference, 1 longitude difference,
  // 2 first latitude, 3 second latitude.
  // --------------------------------------------------------------------------
  logic signed [TW-1:0] ang  [4];
  logic signed [PW-1:0] prod [4];
  logic signed [ZW-1:0] zq   [4];
  rot_t                 rot_s [4][N+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ang[0] <= TW'(second_latitude)  - TW'(first_latitude);
      ang[1] <= TW'(second_longitude) - TW'(first_longitude);
      ang[2] <= TW'(first_latitude);
      ang[3] <= TW'(second_latitude);
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_front
    // differences carry half the angle, so they take one more bit of shift
    localparam int SH = (l < 2) ? 28 : 27;
    localparam logic signed [PW-1:0] RNDH = PW'(1) << (SH - 1);

    logic signed [PW-1:0] rsum;
    logic signed [PW-1:0] rq;
    rot_t                 fold;

    always_comb begin
      rsum = prod[l] + RNDH;
      rq   = rsum >>> SH;
    end

    // fold angles past a right angle back in and mark the cosine for negation
    always_comb begin
      fold.x    = $signed(GAIN_INV);
      fold.y    = '0;
      fold.z    = zq[l];
      fold.flip = 1'b0;
      if (zq[l] > HP) begin
        fold.z    = PI - zq[l];
        fold.flip = 1'b1;
      end else if (zq[l] < -HP) begin
        fold.z    = -PI - zq[l];
        fold.flip = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        prod[l]     <= ang[l] * $signed({1'b0, RAD_K[31:0]});
        zq[l]       <= {rq[ZW-2:0], 1'b0};
        rot_s[l][0] <= fold;
      end
    end

    for (genvar k = 0; k < N; k++) begin : g_rot
      hvd_rot_cell #(.IDX(k)) u_rot (
        .clk (clk),
        .adv (adv),
        .d   (rot_s[l][k]),
        .q   (rot_s[l][k+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // a = sin^2(dlat/2) + sin^2(dlon/2) * cos(lat1) * cos(lat2)
  // --------------------------------------------------------------------------
  logic signed [XW-1:0]      sl, so;
  logic signed [CW-1:0]      cx1, cx2;
  logic signed [2*XW-1:0]    m_l, m_o;
  logic signed [QW+CW-1:0]   m_2, m_3;
  logic signed [QW:0]        a_sum;
  logic        [AW-1:0]      a_clamp;

  logic signed [QW-1:0] p1_t1, p1_t2, p2_t1, p2_t2, p3_t1, p3_t2;
  logic signed [CW-1:0] p1_c1, p1_c2, p2_c2;
  sqrt_t                sq_s [2][SQRT_STEPS+1];

  always_comb begin
    sl  = rot_s[0][N].y;
    so  = rot_s[1][N].y;
    cx1 = {rot_s[2][N].x[XW-1], rot_s[2][N].x};
    cx2 = {rot_s[3][N].x[XW-1], rot_s[3][N].x};
    m_l = sl * sl;
    m_o = so * so;
    m_2 = p1_t2 * p1_c1;
    m_3 = p2_t2 * p2_c2;
    a_sum = QW'(p3_t1) + QW'(p3_t2);
    // clamp a into [0, 1]
    if (a_sum[QW]) begin
      a_clamp = '0;
    end else if (a_sum > $signed((QW+1)'(ONE_Q30))) begin
      a_clamp = ONE_Q30;
    end else begin
      a_clamp = a_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_t1 <= QW'((m_l + RND1) >>> 30);
      p1_t2 <= QW'((m_o + RND1) >>> 30);
      p1_c1 <= rot_s[2][N].flip ? -cx1 : cx1;
      p1_c2 <= rot_s[3][N].flip ? -cx2 : cx2;

      p2_t1 <= p1_t1;
      p2_t2 <= QW'((m_2 + RND2) >>> 30);
      p2_c2 <= p1_c2;

      p3_t1 <= p2_t1;
      p3_t2 <= QW'((m_3 + RND2) >>> 30);

      sq_s[0][0].rem  <= RW'(a_clamp) << 30;
      sq_s[0][0].root <= '0;
      sq_s[1][0].rem  <= RW'(ONE_Q30 - a_clamp) << 30;
      sq_s[1][0].root <= '0;
    end
  end

  // --------------------------------------------------------------------------
  // sqrt(a) and sqrt(1 - a), one result bit per cell
  // --------------------------------------------------------------------------
  for (genvar l = 0; l < 2; l++) begin : g_sqrt
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      hvd_sqrt_cell #(.STEP(k)) u_sqrt (
        .clk (clk),
        .adv (adv),
        .d   (sq_s[l][k]),
        .q   (sq_s[l][k+1])
      );
    end
  end

  // --------------------------------------------------------------------------
  // c = 2 * atan2(sqrt(a), sqrt(1 - a))
  // --------------------------------------------------------------------------
  vec_t vec_s [N+1];

  assign vec_s[0].x = $signed({2'b0, sq_s[1][SQRT_STEPS].root[AW-1:0]});
  assign vec_s[0].y = $signed({2'b0, sq_s[0][SQRT_STEPS].root[AW-1:0]});
  assign vec_s[0].z = '0;

  for (genvar k = 0; k < N; k++) begin : g_vec
    hvd_vec_cell #(.IDX(k)) u_vec (
      .clk (clk),
      .adv (adv),
      .d   (vec_s[k]),
      .q   (vec_s[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output: scale by radius, round, saturate; hold while blocked
  // --------------------------------------------------------------------------
  logic [VW-1:0]    c_ang;
  logic [VW+15:0]   d_prod;
  logic [VW-6:0]    d_rnd;

  always_comb begin
    d_prod = radius * c_ang;
    d_rnd  = (VW-5)'((d_prod + (VW+16)'(1 << 21)) >> 22);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // drop a slightly negative angle to zero
      c_ang       <= vec_s[N].z[VW-1] ? '0 : {vec_s[N].z[VW-2:0], 1'b0};
      distance_q8 <= (d_rnd > (VW-5)'(24'hFFFFFF)) ? 24'hFFFFFF : d_rnd[23:0];
    end
  end

endmodule

// ----- hdl/hvd_chk.sv -----
// ----------------------------------------------------------------------------
// hvd_chk
// Port-level checks on the distance block, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hvd_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] distance_q8,
  input logic        psel,
  input logic        pwrite,
  input logic  [2:0] paddr,
  input logic [31:0] prdata
);

  `HVD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(distance_q8), "blocked item changed")
  `HVD_ASSERT_IMP(a_ready, clk, rst, in_valid || !in_valid,
    in_ready == (!out_valid || out_ready), "ready does not follow output")
  `HVD_ASSERT_IMP(a_reset_empty, clk, rst, $past(rst),
    !out_valid, "item shown right after reset")
  `HVD_ASSERT_IMP(a_radius_read, clk, rst, psel && !pwrite && (paddr[2] == 1'b0),
    prdata[31:16] == 16'h0000, "radius read has upper bits set")

endmodule

bind haversine_distance hvd_chk u_hvd_chk (.*);

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the great-circle distance pipeline. Position pairs
// go in through a valid/ready channel, and a bit-exact fixed-point predictor
// works out each distance from them. The bench compares the results in order
// and runs several radius settings, written through the APB port while the
// block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the radius setting and the queue of predicted distances.
class distance_board;
  localparam int STAGES = 24;
  longint unsigned radius;
  longint unsigned pending[$];
  int errors;

  function new();
    radius = hvd_pkg::RADIUS_RESET;
    errors = 0;
  endfunction

  // Round half up at bit s: add half, then floor.
  function longint rnd(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  // Convert an angle in ten-thousandths of a minute to Q30 radians
  // (rounded to Q3.29 first).
  function longint to_rad(longint t, int s);
    return 2 * rnd(t * longint'(hvd_pkg::RAD_K), s);
  endfunction

  // Rotation CORDIC: fold beyond a right angle and negate the cosine there.
  function void rotate(longint z_in, output longint s, output longint c);
    longint x, y, z, dx, dy, pi, hpi;
    bit flip;
    pi = longint'(hvd_pkg::PI_Q30);
    hpi = longint'(hvd_pkg::HALF_PI_Q30);
    x = longint'(hvd_pkg::GAIN_INV);
    y = 0;
    z = z_in;
    flip = 0;
    if (z > hpi) begin
      z = pi - z;
      flip = 1;
    end else if (z < -hpi) begin
      z = -pi - z;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(hvd_pkg::ATAN_Q30[i]);
      end else begin
        x += dx; y -= dy; z += longint'(hvd_pkg::ATAN_Q30[i]);
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  // Vectoring CORDIC: accumulated angle of (x, y).
  function longint angle_of(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; z += longint'(hvd_pkg::ATAN_Q30[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(hvd_pkg::ATAN_Q30[i]);
      end
    end
    return z;
  endfunction

  function longint unsigned root_of(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Predict the distance for one accepted position pair and queue it.
  function void note_pair(logic signed [27:0] lon1, logic signed [26:0] lat1,
                          logic signed [27:0] lon2, logic signed [26:0] lat2);
    longint sl, so, c1, c2, dummy, a, t1, t2, c, d, one;
    one = longint'(1) << 30;
    rotate(to_rad(longint'(lat2) - longint'(lat1), 28), sl, dummy);
    rotate(to_rad(longint'(lon2) - longint'(lon1), 28), so, dummy);
    rotate(to_rad(longint'(lat1), 27), dummy, c1);
    rotate(to_rad(longint'(lat2), 27), dummy, c2);
    t1 = rnd(sl * sl, 30);
    t2 = rnd(so * so, 30);
    t2 = rnd(t2 * c1, 30);
    t2 = rnd(t2 * c2, 30);
    a = t1 + t2;
    if (a < 0) a = 0;
    if (a > one) a = one;
    c = 2 * angle_of(longint'(root_of(longint'(a) << 30)),
                     longint'(root_of(longint'(one - a) << 30)));
    if (c < 0) c = 0;
    d = rnd(longint'(radius) * c, 22);
    if (d > 16777215) d = 16777215;
    pending.push_back(d);
  endfunction

  // Compare one delivered distance with the oldest prediction.
  function void check_distance(logic [23:0] got);
    longint unsigned want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected distance, expected none, actual %0d", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want[23:0]) begin
      $display("%0t: distance_q8 mismatch, expected %0d, actual %0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import hvd_pkg::*;

  localparam int LATENCY = 89;
  localparam longint LON_MAX = 108600000;
  localparam longint LAT_MAX = 54600000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [27:0] first_longitude = '0;
  logic signed [26:0] first_latitude = '0;
  logic signed [27:0] second_longitude = '0;
  logic signed [26:0] second_latitude = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [23:0] distance_q8;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  distance_board board = new();
  bit calm = 1'b0;   // set for the last part of the run: no idling at all

  haversine_distance uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_longitude(first_longitude), .first_latitude(first_latitude),
    .second_longitude(second_longitude), .second_latitude(second_latitude),
    .out_valid(out_valid), .out_ready(out_ready), .distance_q8(distance_q8),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // Receiver: drop ready in random bursts, changing it at the falling edge.
  int stall_left = 0;
  always @(negedge clk) begin
    if (rst || calm) begin
      out_ready <= !rst;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Sample results at the rising edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_distance(distance_q8);
  end

  // Hold one position pair until it is accepted, then maybe idle a burst.
  task automatic send_pair(longint lon1, longint lat1, longint lon2, longint lat2);
    @(negedge clk);
    first_longitude = 28'(lon1);
    first_latitude = 27'(lat1);
    second_longitude = 28'(lon2);
    second_latitude = 27'(lat2);
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_pair(first_longitude, first_latitude, second_longitude, second_latitude);
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
  endtask

  // Setup cycle, then access cycle; the write lands when pready is high.
  task automatic write_radius(logic [15:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {REG_EARTH_RADIUS, 2'b00};
    pwdata = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    board.radius = value;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Drop valid and let the pipeline empty completely.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
  endtask

  function automatic longint pick(longint lim, int bits);
    if ($urandom_range(0, 4) == 0)
      return longint'($signed(($urandom() & ((32'd1 << bits) - 1)) << (32 - bits))) >>> (32 - bits);
    return longint'($urandom_range(0, 2 * lim)) - lim;
  endfunction

  task automatic random_pairs(int n);
    longint lon1, lat1;
    for (int i = 0; i < n; i++) begin
      lon1 = pick(LON_MAX, 28);
      lat1 = pick(LAT_MAX, 27);
      if ($urandom_range(0, 2) == 0)
        // near neighbors: short distances exercise small a
        send_pair(lon1, lat1, lon1 + longint'($urandom_range(0, 2000)) - 1000,
                  lat1 + longint'($urandom_range(0, 2000)) - 1000);
      else
        send_pair(lon1, lat1, pick(LON_MAX, 28), pick(LAT_MAX, 27));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: identical points, poles, antipodes, dateline, field extremes.
    send_pair(0, 0, 0, 0);
    send_pair(LON_MAX, LAT_MAX, LON_MAX, LAT_MAX);
    send_pair(0, LAT_MAX, 0, -LAT_MAX);
    send_pair(0, 0, LON_MAX, 0);
    send_pair(-LON_MAX, 0, LON_MAX, 0);
    send_pair(LON_MAX - 10, 100, -LON_MAX + 10, -100);
    send_pair(-LON_MAX, -LAT_MAX, LON_MAX, LAT_MAX);
    send_pair(1, 0, 0, 0);
    send_pair(0, 1, 0, 0);
    send_pair(54300000, 0, -54300000, 0);
    send_pair(0, 0, 54300000, 0);
    send_pair(0, 27300000, 108600000, 27300000);
    // Latitudes beyond a pole and raw field extremes: used as given.
    send_pair(0, 67108863, 0, -67108864);
    send_pair(134217727, 0, -134217728, 0);
    send_pair(-134217728, -67108864, 134217727, 67108863);
    send_pair(134217727, 67108863, 134217727, 67108863);
    send_pair(-1, -1, 1, 1);
    send_pair(12345678, -2345678, -98765432, 43210987);
    random_pairs(80);
    drain();

    // Smallest nonzero radius, then largest (saturates on long hauls).
    write_radius(16'd1);
    send_pair(-LON_MAX, 0, LON_MAX, 0);
    random_pairs(90);
    drain();
    write_radius(16'hFFFF);
    send_pair(0, LAT_MAX, 0, -LAT_MAX);
    send_pair(0, 0, 1, 0);
    random_pairs(90);
    drain();
    write_radius(16'($urandom_range(2, 65534)));
    random_pairs(90);
    drain();

    // Back to the default radius; last stretch with no idling on either side.
    write_radius(RADIUS_RESET);
    random_pairs(60);
    calm = 1'b1;
    random_pairs(90);
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);

    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop if the run hangs.
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hdl
hdl/hvd_pkg.sv
hdl/hvd_rot_cell.sv
hdl/hvd_sqrt_cell.sv
hdl/hvd_vec_cell.sv
hdl/haversine_distance.sv
hdl/hvd_chk.sv
verif/tb_top.sv
